// ----- rtl/core/ddd_pkg.sv -----
// Shared types, widths and calendar constants for the date difference block.
`default_nettype none
package ddd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int DNUM_W  = 23;
  localparam int OPND_W  = 15;
  localparam int COEF_W  = 15;
  localparam int PROD_W  = OPND_W + COEF_W;
  localparam int QUOT_W  = 9;
  localparam int MSUM_W  = 9;

  // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for v < 2**OPND_W
  localparam int RECIP_SHIFT = 21;
  localparam logic [COEF_W-1:0] RECIP_100     = COEF_W'(20972);
  localparam logic [COEF_W-1:0] DAYS_PER_YEAR = COEF_W'(365);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = '1;

  typedef enum logic [3:0] {
    DN_IDLE,
    DN_MUL0,
    DN_MUL1,
    DN_MUL2,
    DN_MUL3,
    DN_MUL4,
    DN_YEAR,
    DN_CENT,
    DN_QUAD,
    DN_MONTH
  } dn_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DATE_A,
    T_DATE_B,
    T_DIFF
  } top_state_t;

  typedef struct packed {
    logic              done;
    logic [DNUM_W-1:0] value;
  } dn_result_t;

  // days in the whole months before month m of a common year
  function automatic logic [MSUM_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MSUM_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ddd_day_num.sv -----
// Day number of one date from a shared multiplier and accumulator sequencer.
`default_nettype none
module ddd_day_num (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ddd_pkg::YEAR_W-1:0]   year,
  input  wire logic [ddd_pkg::MONTH_W-1:0]  month,
  input  wire logic [ddd_pkg::DAY_W-1:0]    day,
  output ddd_pkg::dn_result_t               res
);
  import ddd_pkg::*;

  dn_state_t           state, state_next;
  logic [YEAR_W-1:0]   y;
  logic [MONTH_W-1:0]  m;
  logic [DAY_W-1:0]    d;
  logic [OPND_W-1:0]   opnd;
  logic [COEF_W-1:0]   coef;
  logic [PROD_W-1:0]   prod, prod_next;
  logic [QUOT_W-1:0]   quot;
  logic [QUOT_W-1:0]   c100, f100, c400, f400;
  logic [DNUM_W-1:0]   acc;
  logic                done;
  logic [OPND_W-1:0]   y_ext;
  logic [OPND_W-1:0]   quarter;
  logic                leap;
  logic [MSUM_W-1:0]   mon_add;

  assign y_ext     = OPND_W'(y);
  assign quarter   = (y_ext + OPND_W'(3)) >> 2;
  assign quot      = prod[RECIP_SHIFT +: QUOT_W];
  assign prod_next = PROD_W'(opnd) * PROD_W'(coef);
  assign leap      = (y[1:0] == 2'b00) && ((c100 != f100) || (c400 == f400));
  assign mon_add   = month_start(m) + MSUM_W'(leap && (m > MONTH_FEB)) + MSUM_W'(d);

  always_comb begin
    state_next = state;
    opnd       = '0;
    coef       = RECIP_100;
    case (state)
      DN_IDLE: begin
        if (start) state_next = DN_MUL0;
      end
      DN_MUL0: begin
        opnd       = y_ext + OPND_W'(99);
        state_next = DN_MUL1;
      end
      DN_MUL1: begin
        opnd       = y_ext;
        state_next = DN_MUL2;
      end
      DN_MUL2: begin
        opnd       = (y_ext + OPND_W'(399)) >> 2;
        state_next = DN_MUL3;
      end
      DN_MUL3: begin
        opnd       = y_ext >> 2;
        state_next = DN_MUL4;
      end
      DN_MUL4: begin
        opnd       = y_ext;
        coef       = DAYS_PER_YEAR;
        state_next = DN_YEAR;
      end
      DN_YEAR:  state_next = DN_CENT;
      DN_CENT:  state_next = DN_QUAD;
      DN_QUAD:  state_next = DN_MONTH;
      DN_MONTH: state_next = DN_IDLE;
      default:  state_next = DN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DN_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DN_MONTH);
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (state == DN_IDLE && start) begin
      y <= year;
      d <= day;
      if (month < MONTH_JAN) begin
        m <= MONTH_JAN;
      end else if (month > MONTH_DEC) begin
        m <= MONTH_DEC;
      end else begin
        m <= month;
      end
    end
    case (state)
      DN_MUL1:  c100 <= quot;
      DN_MUL2:  f100 <= quot;
      DN_MUL3:  c400 <= quot;
      DN_MUL4:  f400 <= quot;
      DN_YEAR:  acc  <= prod[DNUM_W-1:0] + DNUM_W'(quarter);
      DN_CENT:  acc  <= acc - DNUM_W'(c100);
      DN_QUAD:  acc  <= acc + DNUM_W'(c400);
      DN_MONTH: acc  <= acc + DNUM_W'(mon_add);
      default: begin
      end
    endcase
  end

  assign res.done  = done;
  assign res.value = acc;

endmodule
`default_nettype wire

// ----- rtl/core/date_difference_days.sv -----
// Top level: days between two Gregorian dates, one pair per request word.
`default_nettype none
// Takes a request word holding two dates (year, month, day) and returns one
// response word with the absolute number of days between them, saturated at
// all ones. Month 0 counts as January, months above 12 as December; days are
// not checked. Each date goes through one multiplier-and-accumulator
// sequencer in turn, date A and then date B; req_stall stays high while
// a pair is in work. The response sits in an output register, so the next
// request is taken while the previous response still waits.
module date_difference_days (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [ddd_pkg::YEAR_W-1:0]   year_a,
  input  wire logic [ddd_pkg::MONTH_W-1:0]  month_a,
  input  wire logic [ddd_pkg::DAY_W-1:0]    day_a,
  input  wire logic [ddd_pkg::YEAR_W-1:0]   year_b,
  input  wire logic [ddd_pkg::MONTH_W-1:0]  month_b,
  input  wire logic [ddd_pkg::DAY_W-1:0]    day_b,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [ddd_pkg::COUNT_W-1:0]       day_count
);
  import ddd_pkg::*;

  top_state_t          state, state_next;
  logic [YEAR_W-1:0]   yb;
  logic [MONTH_W-1:0]  mb;
  logic [DAY_W-1:0]    db;
  logic [DNUM_W-1:0]   na;
  logic                req_take;
  logic                dn_start;
  logic [YEAR_W-1:0]   dn_year;
  logic [MONTH_W-1:0]  dn_month;
  logic [DAY_W-1:0]    dn_day;
  dn_result_t          dn_res;
  logic [DNUM_W-1:0]   diff;
  logic [COUNT_W-1:0]  diff_sat;
  logic                out_free;
  logic                load;

  assign req_stall = (state != T_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign diff      = (na >= dn_res.value) ? (na - dn_res.value) : (dn_res.value - na);
  assign diff_sat  = diff[DNUM_W-1] ? DAY_COUNT_MAX : diff[COUNT_W-1:0];

  always_comb begin
    state_next = state;
    dn_start   = 1'b0;
    dn_year    = year_a;
    dn_month   = month_a;
    dn_day     = day_a;
    load       = 1'b0;
    case (state)
      T_IDLE: begin
        if (req_take) begin
          dn_start   = 1'b1;
          state_next = T_DATE_A;
        end
      end
      T_DATE_A: begin
        dn_year  = yb;
        dn_month = mb;
        dn_day   = db;
        if (dn_res.done) begin
          dn_start   = 1'b1;
          state_next = T_DATE_B;
        end
      end
      T_DATE_B: begin
        if (dn_res.done) state_next = T_DIFF;
      end
      T_DIFF: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      yb <= year_b;
      mb <= month_b;
      db <= day_b;
    end
    if (state == T_DATE_A && dn_res.done) na <= dn_res.value;
    if (load) day_count <= diff_sat;
  end

  ddd_day_num u_day_num (
    .clk   (clk),
    .rst   (rst),
    .start (dn_start),
    .year  (dn_year),
    .month (dn_month),
    .day   (dn_day),
    .res   (dn_res)
  );

  a_take_starts_a: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == T_DATE_A)
    else $error("accepted request did not start first date");

  a_done_in_date: assert property (@(posedge clk) disable iff (rst)
    dn_res.done |-> (state == T_DATE_A || state == T_DATE_B))
    else $error("day number finished outside a date phase");

  a_rsp_from_diff: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == T_DIFF)
    else $error("response raised without a finished pair");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for date_difference_days: directed and random date pairs checked against a predictor.
`default_nettype none

class span_tracker;
  logic [ddd_pkg::COUNT_W-1:0] expected_counts[$];
  int unsigned mismatches = 0;

  static function bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  static function int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      2:          return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // days from 1 January of year 0, month clamped to 1..12, day taken as is
  static function int unsigned day_index(logic [ddd_pkg::YEAR_W-1:0] y,
                                         logic [ddd_pkg::MONTH_W-1:0] m,
                                         logic [ddd_pkg::DAY_W-1:0] d);
    int unsigned yy;
    int unsigned mm;
    int unsigned n;
    yy = y;
    mm = m;
    if (mm < 1) mm = 1;
    if (mm > 12) mm = 12;
    n = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    for (int unsigned i = 1; i < mm; i++) n += month_length(yy, i);
    return n + d;
  endfunction

  function void note_dates(logic [ddd_pkg::YEAR_W-1:0] ya, logic [ddd_pkg::MONTH_W-1:0] ma,
                           logic [ddd_pkg::DAY_W-1:0] da, logic [ddd_pkg::YEAR_W-1:0] yb,
                           logic [ddd_pkg::MONTH_W-1:0] mb, logic [ddd_pkg::DAY_W-1:0] db);
    int unsigned na;
    int unsigned nb;
    int unsigned span;
    na = day_index(ya, ma, da);
    nb = day_index(yb, mb, db);
    span = (na >= nb) ? na - nb : nb - na;
    if (span > ddd_pkg::DAY_COUNT_MAX) span = ddd_pkg::DAY_COUNT_MAX;
    expected_counts.push_back(span[ddd_pkg::COUNT_W-1:0]);
  endfunction

  function void check_span(logic [ddd_pkg::COUNT_W-1:0] got);
    logic [ddd_pkg::COUNT_W-1:0] want;
    if (expected_counts.size() == 0) begin
      $display("%0t: day_count %0d arrived with no pair outstanding", $time, got);
      mismatches++;
    end else begin
      want = expected_counts.pop_front();
      if (got !== want) begin
        $display("%0t: day_count mismatch, expected %0d, got %0d", $time, want, got);
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return expected_counts.size();
  endfunction
endclass

module testbench;
  import ddd_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [YEAR_W-1:0]  year_a = '0;
  logic [MONTH_W-1:0] month_a = '0;
  logic [DAY_W-1:0]   day_a = '0;
  logic [YEAR_W-1:0]  year_b = '0;
  logic [MONTH_W-1:0] month_b = '0;
  logic [DAY_W-1:0]   day_b = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [COUNT_W-1:0] day_count;

  bit quiet = 1'b0;
  bit start_hold = 1'b0;

  span_tracker board = new();

  date_difference_days DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall)
      board.note_dates(year_a, month_a, day_a, year_b, month_b, day_b);
    if (!rst && rsp_valid && !rsp_stall)
      board.check_span(day_count);
  end

  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else if (start_hold && !hold_done) begin
        rsp_stall <= 1'b1;
        hold_left = 299;
      end else if (quiet) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send_dates(input int unsigned ya, input int unsigned ma, input int unsigned da,
                            input int unsigned yb, input int unsigned mb, input int unsigned db);
    if (!quiet) begin
      while ($urandom_range(99) < 38) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    year_a  <= ya[YEAR_W-1:0];
    month_a <= ma[MONTH_W-1:0];
    day_a   <= da[DAY_W-1:0];
    year_b  <= yb[YEAR_W-1:0];
    month_b <= mb[MONTH_W-1:0];
    day_b   <= db[DAY_W-1:0];
    do @(posedge clk); while (req_stall);
  endtask

  task automatic pick_date(output int unsigned y, output int unsigned m, output int unsigned d);
    y = $urandom_range(9999, 1);
    m = $urandom_range(12, 1);
    d = $urandom_range(board.month_length(y, m), 1);
  endtask

  task automatic send_random_pair();
    int unsigned ya, ma, da, yb, mb, db;
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(99);
    pick_date(ya, ma, da);
    pick_date(yb, mb, db);
    if (pick < 55) begin
    end else if (pick < 70) begin
      yb = ya;
      db = $urandom_range(board.month_length(yb, mb), 1);
    end else if (pick < 80) begin
      step = $urandom_range(3);
      yb = ($urandom_range(1) == 1) ? ya + step : ya - step;
      if (yb < 1 || yb > 9999) yb = ya;
      db = $urandom_range(board.month_length(yb, mb), 1);
    end else begin
      ya = $urandom_range(16383);
      ma = $urandom_range(15);
      da = $urandom_range(31);
      yb = $urandom_range(16383);
      mb = $urandom_range(15);
      db = $urandom_range(31);
    end
    send_dates(ya, ma, da, yb, mb, db);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_dates(2000, 2, 29, 2000, 2, 29);
    send_dates(1, 1, 1, 9999, 12, 31);
    send_dates(9999, 12, 31, 1, 1, 1);
    send_dates(2000, 2, 28, 2000, 3, 1);
    send_dates(1900, 2, 28, 1900, 3, 1);
    send_dates(2004, 3, 1, 2004, 2, 28);
    send_dates(2100, 2, 28, 2100, 3, 1);
    send_dates(2400, 12, 31, 2401, 1, 1);
    send_dates(2023, 1, 15, 2023, 11, 30);
    send_dates(1999, 12, 31, 2000, 1, 1);
    send_dates(2021, 0, 10, 2021, 1, 10);
    send_dates(2021, 13, 5, 2021, 12, 5);
    send_dates(2021, 15, 31, 2020, 0, 0);
    send_dates(2023, 2, 31, 2023, 3, 3);
    send_dates(2023, 3, 0, 2023, 2, 28);
    send_dates(0, 1, 1, 1, 1, 1);
    send_dates(0, 3, 1, 0, 2, 1);
    send_dates(16383, 15, 31, 0, 0, 0);
    send_dates(0, 1, 1, 16383, 12, 31);
    send_dates(12000, 6, 15, 1, 1, 1);
    send_dates(16383, 1, 1, 9999, 12, 31);
    send_dates(10000, 2, 29, 10000, 3, 1);

    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    for (int k = 0; k < 1700; k++) begin
      if (k == 400) begin
        quiet = 1'b1;
        start_hold = 1'b1;
      end
      if (k == 700) quiet = 1'b0;
      if (k == 1200) begin
        req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
      send_random_pair();
    end
    req_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
